[rtl/alclk_pkg.sv]
// alarm clock package: phase type, digit and button types, button codes,
// digit limits and small decimal helper functions
// no dependencies
package alclk_pkg;

    typedef enum logic [1:0] {
        PH_SET_TIME  = 2'd0,
        PH_SET_ALARM = 2'd1,
        PH_RUN       = 2'd2
    } phase_t;

    localparam int DIGIT_COUNT = 6;

    localparam int BTN_UP    = 1;
    localparam int BTN_LEFT  = 3;
    localparam int BTN_RIGHT = 5;
    localparam int BTN_DOWN  = 7;

    typedef logic [3:0] digit_t;
    typedef digit_t [DIGIT_COUNT-1:0] digits_t;
    typedef logic [2:0] cursor_t;

    localparam cursor_t CURSOR_LAST = cursor_t'(DIGIT_COUNT - 1);

    localparam digit_t DIGIT_LIMIT [DIGIT_COUNT] = '{
        4'd2, 4'd3, 4'd5, 4'd9, 4'd5, 4'd9
    };

    typedef struct packed {
        logic up;
        logic left;
        logic right;
        logic down;
    } btn_t;

    typedef struct packed {
        logic    advance;
        cursor_t cursor;
        digits_t digits;
        digits_t load_digits;
    } edit_res_t;

    function automatic logic [6:0] pair_value(digit_t tens, digit_t units);
        logic [6:0] t7;
        t7 = {3'b000, tens};
        return (t7 << 3) + (t7 << 1) + {3'b000, units};
    endfunction

    function automatic logic [2:0] tens_of(logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)
            t = 3'd6;
        else if (v >= 6'd50)
            t = 3'd5;
        else if (v >= 6'd40)
            t = 3'd4;
        else if (v >= 6'd30)
            t = 3'd3;
        else if (v >= 6'd20)
            t = 3'd2;
        else if (v >= 6'd10)
            t = 3'd1;
        else
            t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(logic [5:0] v);
        logic [5:0] t6;
        logic [5:0] diff;
        t6 = {3'b000, tens_of(v)};
        diff = v - ((t6 << 3) + (t6 << 1));
        return diff[3:0];
    endfunction

endpackage

[rtl/alarm_clock_with_digit_setting.sv]
// alarm clock top level: time, alarm and edit state, result register
// depends on alclk_pkg and alclk_edit
//
// usage
// - input channel (in_valid/in_ready): mode 0 is a one-second tick, mode 1 a
//   push-button sample in buttons (bit 1 up, bit 3 left, bit 5 right, bit 7 down)
// - output channel (out_valid/out_ready): one result per input transaction with
//   phase, cursor, six display digits and alarm_match, all after the item
// - phase 0 sets the clock, phase 1 sets the alarm, phase 2 runs; moving right
//   from the last digit ends a setting phase
// - the result is valid the cycle after the input transaction
// - throughput: one item per cycle while out_ready is high; state and result
//   update in a single registered pass through the editor and the time carry logic
// - the input is taken while a result is being read out (in_ready is high when
//   the result register is empty or out_ready is high)
// - when the receiver stalls, the result holds and in_ready drops
// - reset clears time, alarm, digits, cursor and phase to zero, and empties
//   the result register
module alarm_clock_with_digit_setting
    import alclk_pkg::*;
#(
    parameter int BUTTON_COUNT = 9
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    mode,
    input  logic [BUTTON_COUNT-1:0] buttons,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              phase,
    output logic [2:0]              cursor,
    output logic [1:0]              digit_hour_tens,
    output logic [3:0]              digit_hour_units,
    output logic [2:0]              digit_minute_tens,
    output logic [3:0]              digit_minute_units,
    output logic [2:0]              digit_second_tens,
    output logic [3:0]              digit_second_units,
    output logic                    alarm_match
);

    phase_t      phase_reg, phase_next;
    cursor_t     cursor_reg, cursor_next;
    digits_t     digits_reg, digits_next;
    logic [4:0]  hours_reg, hours_next;
    logic [5:0]  minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [4:0]  alarm_h_reg, alarm_h_next;
    logic [5:0]  alarm_m_reg, alarm_m_next;
    logic [5:0]  alarm_s_reg, alarm_s_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_phase_reg;
    logic [2:0]  out_cursor_reg;
    logic [1:0]  out_ht_reg;
    logic [3:0]  out_hu_reg;
    logic [2:0]  out_mt_reg;
    logic [3:0]  out_mu_reg;
    logic [2:0]  out_st_reg;
    logic [3:0]  out_su_reg;
    logic        out_match_reg;

    logic        in_accept;
    logic        editing;
    logic        ticking;
    logic        running_next;
    btn_t        btn;
    edit_res_t   edit_res;
    logic [4:0]  load_h;
    logic [5:0]  load_m;
    logic [5:0]  load_s;
    logic [6:0]  pair_h, pair_m, pair_s;
    logic [2:0]  hour_tens_full;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign btn.up    = buttons[BTN_UP];
    assign btn.left  = buttons[BTN_LEFT];
    assign btn.right = buttons[BTN_RIGHT];
    assign btn.down  = buttons[BTN_DOWN];

    alclk_edit u_edit (
        .cursor (cursor_reg),
        .digits (digits_reg),
        .btn    (btn),
        .result (edit_res)
    );

    assign editing = in_accept && mode &&
                     (phase_reg == PH_SET_TIME || phase_reg == PH_SET_ALARM);
    assign ticking = in_accept && !mode && phase_reg != PH_SET_TIME;

    assign pair_h = pair_value(edit_res.load_digits[0], edit_res.load_digits[1]);
    assign pair_m = pair_value(edit_res.load_digits[2], edit_res.load_digits[3]);
    assign pair_s = pair_value(edit_res.load_digits[4], edit_res.load_digits[5]);
    assign load_h = pair_h[4:0];
    assign load_m = pair_m[5:0];
    assign load_s = pair_s[5:0];

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (editing && edit_res.advance)
        begin
            case (phase_reg)
                PH_SET_TIME:  phase_next = PH_SET_ALARM;
                PH_SET_ALARM: phase_next = PH_RUN;
                default:      phase_next = phase_reg;
            endcase
        end
    end

    // edit, load and time carry
    always_comb
    begin
        cursor_next  = cursor_reg;
        digits_next  = digits_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        alarm_h_next = alarm_h_reg;
        alarm_m_next = alarm_m_reg;
        alarm_s_next = alarm_s_reg;

        if (editing)
        begin
            cursor_next = edit_res.cursor;
            digits_next = edit_res.digits;
            if (phase_reg == PH_SET_TIME)
            begin
                hours_next   = load_h;
                minutes_next = load_m;
                seconds_next = load_s;
            end
            else
            begin
                alarm_h_next = load_h;
                alarm_m_next = load_m;
                alarm_s_next = load_s;
            end
        end
        else if (ticking)
        begin
            if (seconds_reg >= 6'd59)
            begin
                seconds_next = 6'd0;
                if (minutes_reg >= 6'd59)
                begin
                    minutes_next = 6'd0;
                    hours_next   = (hours_reg >= 5'd23) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                    minutes_next = minutes_reg + 6'd1;
            end
            else
                seconds_next = seconds_reg + 6'd1;
        end
    end

    // result register contents
    assign running_next   = (phase_next != PH_SET_TIME) && (phase_next != PH_SET_ALARM);
    assign out_valid_next = in_accept || (out_valid_reg && !out_ready);
    assign hour_tens_full = tens_of({1'b0, hours_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SET_TIME;
            cursor_reg    <= '0;
            digits_reg    <= '0;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            seconds_reg   <= '0;
            alarm_h_reg   <= '0;
            alarm_m_reg   <= '0;
            alarm_s_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cursor_reg    <= cursor_next;
            digits_reg    <= digits_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            alarm_h_reg   <= alarm_h_next;
            alarm_m_reg   <= alarm_m_next;
            alarm_s_reg   <= alarm_s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_phase_reg  <= running_next ? PH_RUN : phase_next;
            out_cursor_reg <= cursor_next;
            out_match_reg  <= running_next && hours_next == alarm_h_next &&
                              minutes_next == alarm_m_next &&
                              seconds_next == alarm_s_next;
            if (running_next)
            begin
                out_ht_reg <= hour_tens_full[1:0];
                out_hu_reg <= units_of({1'b0, hours_next});
                out_mt_reg <= tens_of(minutes_next);
                out_mu_reg <= units_of(minutes_next);
                out_st_reg <= tens_of(seconds_next);
                out_su_reg <= units_of(seconds_next);
            end
            else
            begin
                out_ht_reg <= digits_next[0][1:0];
                out_hu_reg <= digits_next[1];
                out_mt_reg <= digits_next[2][2:0];
                out_mu_reg <= digits_next[3];
                out_st_reg <= digits_next[4][2:0];
                out_su_reg <= digits_next[5];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign phase              = out_phase_reg;
    assign cursor             = out_cursor_reg;
    assign digit_hour_tens    = out_ht_reg;
    assign digit_hour_units   = out_hu_reg;
    assign digit_minute_tens  = out_mt_reg;
    assign digit_minute_units = out_mu_reg;
    assign digit_second_tens  = out_st_reg;
    assign digit_second_units = out_su_reg;
    assign alarm_match        = out_match_reg;

endmodule

[rtl/alclk_edit.sv]
// digit editor: applies one button sample to cursor and edit digits
// depends on alclk_pkg
module alclk_edit
    import alclk_pkg::*;
(
    input  cursor_t   cursor,
    input  digits_t   digits,
    input  btn_t      btn,
    output edit_res_t result
);

    digits_t d_up;
    digits_t d_down;
    cursor_t c_left;
    cursor_t c_right;
    logic    advance;

    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (btn.up && cursor == cursor_t'(i) && digits[i] < DIGIT_LIMIT[i])
                d_up[i] = digits[i] + 4'd1;
            else
                d_up[i] = digits[i];
        end

        c_left  = (btn.left && cursor != 3'd0) ? cursor - 3'd1 : cursor;
        advance = btn.right && (c_left == CURSOR_LAST);
        c_right = btn.right ? c_left + 3'd1 : c_left;

        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (btn.down && c_right == cursor_t'(i) && d_up[i] != 4'd0)
                d_down[i] = d_up[i] - 4'd1;
            else
                d_down[i] = d_up[i];
        end

        result.advance     = advance;
        result.cursor      = advance ? 3'd0 : c_right;
        result.digits      = advance ? '0 : d_down;
        result.load_digits = advance ? d_up : d_down;
    end

endmodule

[rtl/alclk_checker.sv]
// port-level checker for the alarm clock, attached by bind
// depends on alclk_pkg and alarm_clock_with_digit_setting port names
module alclk_checker
    import alclk_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] phase,
    input logic [2:0] cursor,
    input logic [1:0] digit_hour_tens,
    input logic [3:0] digit_hour_units,
    input logic [2:0] digit_minute_tens,
    input logic [3:0] digit_minute_units,
    input logic [2:0] digit_second_tens,
    input logic [3:0] digit_second_units,
    input logic       alarm_match
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(cursor) &&
            $stable(digit_hour_tens) && $stable(digit_hour_units) &&
            $stable(digit_minute_tens) && $stable(digit_minute_units) &&
            $stable(digit_second_tens) && $stable(digit_second_units) &&
            $stable(alarm_match))
        else $error("result changed while stalled");

    // empty result register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result register");

    // alarm only reported while running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase != PH_RUN |-> !alarm_match)
        else $error("alarm_match outside running phase");

    // cursor parked at zero while running, in range otherwise
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor <= CURSOR_LAST) && (phase != PH_RUN || cursor == 3'd0))
        else $error("cursor out of range");

endmodule

bind alarm_clock_with_digit_setting alclk_checker u_alclk_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .phase              (phase),
    .cursor             (cursor),
    .digit_hour_tens    (digit_hour_tens),
    .digit_hour_units   (digit_hour_units),
    .digit_minute_tens  (digit_minute_tens),
    .digit_minute_units (digit_minute_units),
    .digit_second_tens  (digit_second_tens),
    .digit_second_units (digit_second_units),
    .alarm_match        (alarm_match)
);
